[rtl/core/ilpm_pkg.sv]
// ilpm_pkg: shared types, codes and reset constants for the idle led power manager
// used by every module under rtl/core; no dependencies
package ilpm_pkg;

  localparam int TIME_W  = 26;
  localparam int LEVEL_W = 8;
  localparam int CNT_W   = 8;
  localparam int ADDR_W  = 3;

  localparam logic [CNT_W-1:0] BRIGHT_DELAY_MS = 8'd20;

  localparam logic [TIME_W-1:0]  RST_TRUE_SLEEP_TIME = 26'd600000;
  localparam logic [TIME_W-1:0]  RST_WIRED_OFF_TIME  = 26'd300000;
  localparam logic [TIME_W-1:0]  RST_WLESS_OFF_TIME  = 26'd60000;
  localparam logic [LEVEL_W-1:0] RST_WIRED_LEVEL     = 8'd255;
  localparam logic [LEVEL_W-1:0] RST_WLESS_LEVEL     = 8'd125;

  typedef enum logic [1:0] {
    PH_ON     = 2'd0,
    PH_OFF    = 2'd1,
    PH_FORCED = 2'd2,
    PH_SLEEP  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_KEY       = 3'd1,
    OP_ENABLE    = 3'd2,
    OP_DISABLE   = 3'd3,
    OP_TOGGLE    = 3'd4,
    OP_MODE_SET  = 3'd5,
    OP_NEW_CONN  = 3'd6,
    OP_CONNECTED = 3'd7
  } opcode_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_TRUE_SLEEP_ON     = 3'd0,
    REG_TRUE_SLEEP_TIME   = 3'd1,
    REG_WIRED_OFF_TIME    = 3'd2,
    REG_WLESS_OFF_TIME    = 3'd3,
    REG_WIRED_BACK_LEVEL  = 3'd4,
    REG_WIRED_UNDER_LEVEL = 3'd5,
    REG_WLESS_BACK_LEVEL  = 3'd6,
    REG_WLESS_UNDER_LEVEL = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic               true_sleep_on;
    logic [TIME_W-1:0]  sleep_time_ms;
    logic [TIME_W-1:0]  wired_off_time_ms;
    logic [TIME_W-1:0]  wireless_off_time_ms;
    logic [LEVEL_W-1:0] wired_back_level;
    logic [LEVEL_W-1:0] wired_under_level;
    logic [LEVEL_W-1:0] wireless_back_level;
    logic [LEVEL_W-1:0] wireless_under_level;
  } cfg_t;

  // packed lowest field last so that brightness_send lands in bit 0
  typedef struct packed {
    phase_t             idle_phase;
    logic               leds_on;
    logic               sleep_send;
    logic [LEVEL_W-1:0] underglow_level;
    logic [LEVEL_W-1:0] backlight_level;
    logic               brightness_send;
  } status_word_t;

  localparam int RESULT_W = $bits(status_word_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

[rtl/core/ilpm_cfg_regs.sv]
// ilpm_cfg_regs: configuration register file written through a plain write port
// depends on ilpm_pkg
module ilpm_cfg_regs
  import ilpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [TIME_W-1:0] cfg_wdata,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.true_sleep_on        <= 1'b0;
      cfg.sleep_time_ms        <= RST_TRUE_SLEEP_TIME;
      cfg.wired_off_time_ms    <= RST_WIRED_OFF_TIME;
      cfg.wireless_off_time_ms <= RST_WLESS_OFF_TIME;
      cfg.wired_back_level     <= RST_WIRED_LEVEL;
      cfg.wired_under_level    <= RST_WIRED_LEVEL;
      cfg.wireless_back_level  <= RST_WLESS_LEVEL;
      cfg.wireless_under_level <= RST_WLESS_LEVEL;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_TRUE_SLEEP_ON:     cfg.true_sleep_on        <= cfg_wdata[0];
        REG_TRUE_SLEEP_TIME:   cfg.sleep_time_ms        <= cfg_wdata;
        REG_WIRED_OFF_TIME:    cfg.wired_off_time_ms    <= cfg_wdata;
        REG_WLESS_OFF_TIME:    cfg.wireless_off_time_ms <= cfg_wdata;
        REG_WIRED_BACK_LEVEL:  cfg.wired_back_level     <= cfg_wdata[LEVEL_W-1:0];
        REG_WIRED_UNDER_LEVEL: cfg.wired_under_level    <= cfg_wdata[LEVEL_W-1:0];
        REG_WLESS_BACK_LEVEL:  cfg.wireless_back_level  <= cfg_wdata[LEVEL_W-1:0];
        REG_WLESS_UNDER_LEVEL: cfg.wireless_under_level <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/ilpm_event_fsm.sv]
// ilpm_event_fsm: idle state machine, brightness debounce and the state registers
// depends on ilpm_pkg; steps once per word presented with step high
module ilpm_event_fsm
  import ilpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  opcode_t      op,
  input  logic         mode_wired,
  input  cfg_t         cfg,
  output status_word_t res
);

  phase_t            phase, phase_next;
  logic              enabled, enabled_next;
  logic              wired, wired_next;
  logic              off_timeout_active, off_timeout_active_next;
  logic              sleep_active, sleep_active_next;
  logic [TIME_W-1:0] idle_timeout, idle_timeout_next;
  logic [TIME_W-1:0] idle_count, idle_count_next;
  logic              conn_pending, conn_pending_next;
  logic              bright_pending, bright_pending_next;
  logic [CNT_W-1:0]  bright_count, bright_count_next;
  logic              send_due, send_due_next;

  logic [TIME_W-1:0] idle_dec;
  logic [CNT_W-1:0]  bright_dec;
  logic [TIME_W-1:0] on_timeout;
  logic              bsend, ssend;

  assign idle_dec   = (idle_count != '0) ? idle_count - 1'b1 : idle_count;
  assign bright_dec = (bright_count != '0) ? bright_count - 1'b1 : bright_count;
  // timeout used on the way back to the on phase; zero disables it
  assign on_timeout = wired ? cfg.wired_off_time_ms : cfg.wireless_off_time_ms;

  always_comb begin
    phase_next              = phase;
    enabled_next            = enabled;
    wired_next              = wired;
    off_timeout_active_next = off_timeout_active;
    sleep_active_next       = sleep_active;
    idle_timeout_next       = idle_timeout;
    idle_count_next         = idle_count;
    conn_pending_next       = conn_pending;
    bright_pending_next     = bright_pending;
    bright_count_next       = bright_count;
    send_due_next           = send_due;
    bsend                   = 1'b0;
    ssend                   = 1'b0;

    case (op)
      OP_TICK: begin
        idle_count_next   = idle_dec;
        bright_count_next = bright_dec;
        case (phase)
          PH_ON: begin
            if (!enabled) begin
              sleep_active_next = wired ? 1'b0 : cfg.true_sleep_on;
              idle_timeout_next = cfg.sleep_time_ms;
              idle_count_next   = cfg.sleep_time_ms;
              phase_next        = PH_FORCED;
            end else if (off_timeout_active && idle_dec == '0) begin
              enabled_next        = 1'b0;
              bright_count_next   = BRIGHT_DELAY_MS;
              bright_pending_next = 1'b1;
              sleep_active_next   = wired ? 1'b0 : cfg.true_sleep_on;
              idle_timeout_next   = cfg.sleep_time_ms;
              idle_count_next     = cfg.sleep_time_ms;
              phase_next          = PH_OFF;
            end
          end
          PH_OFF, PH_FORCED: begin
            if (enabled) begin
              off_timeout_active_next = (on_timeout != '0);
              idle_timeout_next       = on_timeout;
              idle_count_next         = on_timeout;
              phase_next              = PH_ON;
            end else if (sleep_active && idle_dec == '0) begin
              ssend      = 1'b1;
              phase_next = PH_SLEEP;
            end
          end
          default: begin
            if (enabled) begin
              off_timeout_active_next = (on_timeout != '0);
              idle_timeout_next       = on_timeout;
              idle_count_next         = on_timeout;
              phase_next              = PH_ON;
            end
          end
        endcase
        // the message goes out one tick after the delay runs down
        if (send_due) begin
          bsend         = 1'b1;
          send_due_next = 1'b0;
        end else if (bright_pending_next && bright_count_next == '0) begin
          bright_pending_next = 1'b0;
          send_due_next       = 1'b1;
        end
      end
      OP_KEY: begin
        if (phase == PH_OFF) begin
          enabled_next        = 1'b1;
          bright_count_next   = BRIGHT_DELAY_MS;
          bright_pending_next = 1'b1;
        end
        idle_count_next = idle_timeout;
      end
      OP_ENABLE, OP_DISABLE, OP_TOGGLE: begin
        case (op)
          OP_ENABLE:  enabled_next = 1'b1;
          OP_DISABLE: enabled_next = 1'b0;
          default:    enabled_next = !enabled;
        endcase
        bright_count_next   = BRIGHT_DELAY_MS;
        bright_pending_next = 1'b1;
      end
      OP_MODE_SET: begin
        if (wired != mode_wired) begin
          wired_next        = mode_wired;
          sleep_active_next = mode_wired ? 1'b0 : cfg.true_sleep_on;
          idle_timeout_next = cfg.sleep_time_ms;
          idle_count_next   = cfg.sleep_time_ms;
          phase_next        = PH_OFF;
        end
      end
      OP_NEW_CONN: conn_pending_next = 1'b1;
      default: begin
        if (conn_pending) begin
          conn_pending_next = 1'b0;
          idle_count_next   = idle_timeout;
        end
      end
    endcase

    res.brightness_send = bsend;
    res.sleep_send      = ssend;
    res.leds_on         = enabled_next;
    res.idle_phase      = phase_next;
    if (!enabled_next) begin
      res.backlight_level = '0;
      res.underglow_level = '0;
    end else if (wired_next) begin
      res.backlight_level = cfg.wired_back_level;
      res.underglow_level = cfg.wired_under_level;
    end else begin
      res.backlight_level = cfg.wireless_back_level;
      res.underglow_level = cfg.wireless_under_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_OFF;
      enabled            <= 1'b0;
      wired              <= 1'b0;
      off_timeout_active <= 1'b0;
      sleep_active       <= 1'b0;
      idle_timeout       <= RST_TRUE_SLEEP_TIME;
      idle_count         <= RST_TRUE_SLEEP_TIME;
      conn_pending       <= 1'b0;
      bright_pending     <= 1'b0;
      bright_count       <= '0;
      send_due           <= 1'b0;
    end else if (step) begin
      phase              <= phase_next;
      enabled            <= enabled_next;
      wired              <= wired_next;
      off_timeout_active <= off_timeout_active_next;
      sleep_active       <= sleep_active_next;
      idle_timeout       <= idle_timeout_next;
      idle_count         <= idle_count_next;
      conn_pending       <= conn_pending_next;
      bright_pending     <= bright_pending_next;
      bright_count       <= bright_count_next;
      send_due           <= send_due_next;
    end
  end

endmodule

[rtl/core/idle_led_power_manager.sv]
// pipeline: a word accepted into the input reg gives its result word from the result reg
// throughput: one word per cycle; both registers advance together whenever the result
// register is empty or being taken, so the only stall comes from m_axis_tready
// reset: synchronous, clears both valid flags, the event state (phase off, leds disabled,
// idle timer at the true sleep reset time) and loads the register reset values
module idle_led_power_manager
  import ilpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [2:0] opcode, [3] mode_wired, [7:4] zero
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] brightness_send, [8:1] backlight_level, [16:9] underglow_level,
  // [17] sleep_send, [18] leds_on, [20:19] idle_phase, [23:21] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [ADDR_W-1:0]      cfg_addr,
  input  logic [TIME_W-1:0]      cfg_wdata
);

  cfg_t         cfg;
  status_word_t res;
  status_word_t out_word;
  logic         in_valid;
  opcode_t      in_op;
  logic         in_mode_wired;
  logic         advance;
  logic         step;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  ilpm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ilpm_event_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .op         (in_op),
    .mode_wired (in_mode_wired),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op         <= opcode_t'(s_axis_tdata[2:0]);
      in_mode_wired <= s_axis_tdata[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_word};

endmodule

[rtl/core/ilpm_checker.sv]
// ilpm_checker: port-level assertions for idle_led_power_manager, bound to the top level
// depends on ilpm_pkg
module ilpm_checker
  import ilpm_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic               o_ssend, o_leds;
  logic [LEVEL_W-1:0] o_back, o_under;
  phase_t             o_phase;

  assign o_back  = m_axis_tdata[8:1];
  assign o_under = m_axis_tdata[16:9];
  assign o_ssend = m_axis_tdata[17];
  assign o_leds  = m_axis_tdata[18];
  assign o_phase = phase_t'(m_axis_tdata[20:19]);

  // no result can be shown right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  a_dark_levels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !o_leds |-> o_back == '0 && o_under == '0)
    else $error("nonzero levels while leds disabled");

  // a sleep request only happens on entering true sleep with the leds off
  a_sleep_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_ssend |-> o_phase == PH_SLEEP && !o_leds)
    else $error("sleep request outside true sleep");

  // a word taken while the output is stalled fills the input register
  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
      && $past(s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready)
      |-> !s_axis_tready)
    else $error("input taken while pipeline full");

endmodule

bind idle_led_power_manager ilpm_checker u_ilpm_checker (.*);

[tb/tb_top.sv]
// tb_top: self-checking testbench for idle_led_power_manager
// drives event words on the input stream, predicts every status word and checks the output stream
// depends on ilpm_pkg and idle_led_power_manager only
module tb_top;
  import ilpm_pkg::*;

  localparam int CYCLE_LIMIT = 150000;
  localparam int LATENCY     = 2;
  localparam int MAX_PRINTS  = 60;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [ADDR_W-1:0]      cfg_addr;
  logic [TIME_W-1:0]      cfg_wdata;

  idle_led_power_manager DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // predicted copy of the registers and the event state
  cfg_t               model_cfg;
  phase_t             m_phase;
  bit                 m_enabled;
  bit                 m_wired;
  bit                 m_off_armed;
  bit                 m_sleep_armed;
  bit                 m_conn_pending;
  bit                 m_bright_pending;
  bit                 m_send_due;
  logic [TIME_W-1:0]  m_idle_timeout;
  logic [TIME_W-1:0]  m_idle_count;
  logic [CNT_W-1:0]   m_bright_count;

  status_word_t expected_status[$];
  int           errors;
  int           cycle_count;
  bit           sender_gaps;
  bit           receiver_stalls;
  int           hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function void model_reset();
    model_cfg.true_sleep_on        = 1'b0;
    model_cfg.sleep_time_ms        = RST_TRUE_SLEEP_TIME;
    model_cfg.wired_off_time_ms    = RST_WIRED_OFF_TIME;
    model_cfg.wireless_off_time_ms = RST_WLESS_OFF_TIME;
    model_cfg.wired_back_level     = RST_WIRED_LEVEL;
    model_cfg.wired_under_level    = RST_WIRED_LEVEL;
    model_cfg.wireless_back_level  = RST_WLESS_LEVEL;
    model_cfg.wireless_under_level = RST_WLESS_LEVEL;
    m_phase          = PH_OFF;
    m_enabled        = 1'b0;
    m_wired          = 1'b0;
    m_off_armed      = 1'b0;
    m_sleep_armed    = 1'b0;
    m_idle_timeout   = RST_TRUE_SLEEP_TIME;
    m_idle_count     = RST_TRUE_SLEEP_TIME;
    m_conn_pending   = 1'b0;
    m_bright_pending = 1'b0;
    m_bright_count   = '0;
    m_send_due       = 1'b0;
  endfunction

  function void request_brightness();
    m_bright_count   = BRIGHT_DELAY_MS;
    m_bright_pending = 1'b1;
  endfunction

  function void set_leds(bit on);
    m_enabled = on;
    request_brightness();
  endfunction

  function void enter_off(bit forced);
    m_sleep_armed  = m_wired ? 1'b0 : model_cfg.true_sleep_on;
    m_idle_timeout = model_cfg.sleep_time_ms;
    m_idle_count   = m_idle_timeout;
    m_phase        = forced ? PH_FORCED : PH_OFF;
  endfunction

  function void enter_on();
    m_off_armed    = 1'b0;
    m_idle_timeout = '0;
    if (m_wired && model_cfg.wired_off_time_ms != 0) begin
      m_off_armed    = 1'b1;
      m_idle_timeout = model_cfg.wired_off_time_ms;
    end else if (!m_wired && model_cfg.wireless_off_time_ms != 0) begin
      m_off_armed    = 1'b1;
      m_idle_timeout = model_cfg.wireless_off_time_ms;
    end
    m_idle_count = m_idle_timeout;
    m_phase      = PH_ON;
  endfunction

  // one step of the idle machine, returns 1 when the sleep request goes out
  function bit step_idle();
    bit slept;
    slept = 1'b0;
    case (m_phase)
      PH_ON: begin
        if (!m_enabled) begin
          enter_off(1'b1);
        end else if (m_off_armed && m_idle_count == 0) begin
          set_leds(1'b0);
          enter_off(1'b0);
        end
      end
      PH_OFF, PH_FORCED: begin
        if (m_enabled) begin
          enter_on();
        end else if (m_sleep_armed && m_idle_count == 0) begin
          slept   = 1'b1;
          m_phase = PH_SLEEP;
        end
      end
      default: begin
        if (m_enabled) enter_on();
      end
    endcase
    return slept;
  endfunction

  function status_word_t next_led_status(opcode_t op, bit mw);
    status_word_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        if (m_idle_count != 0) m_idle_count--;
        if (m_bright_count != 0) m_bright_count--;
        r.sleep_send = step_idle();
        if (m_send_due) begin
          r.brightness_send = 1'b1;
          m_send_due        = 1'b0;
        end else if (m_bright_pending && m_bright_count == 0) begin
          m_bright_pending = 1'b0;
          m_send_due       = 1'b1;
        end
      end
      OP_KEY: begin
        if (m_phase == PH_OFF) set_leds(1'b1);
        m_idle_count = m_idle_timeout;
      end
      OP_ENABLE:  set_leds(1'b1);
      OP_DISABLE: set_leds(1'b0);
      OP_TOGGLE:  set_leds(!m_enabled);
      OP_MODE_SET: begin
        if (m_wired != mw) begin
          m_wired = mw;
          enter_off(1'b0);
        end
      end
      OP_NEW_CONN: m_conn_pending = 1'b1;
      default: begin
        if (m_conn_pending) begin
          m_conn_pending = 1'b0;
          m_idle_count   = m_idle_timeout;
        end
      end
    endcase
    if (!m_enabled) begin
      r.backlight_level = '0;
      r.underglow_level = '0;
    end else if (m_wired) begin
      r.backlight_level = model_cfg.wired_back_level;
      r.underglow_level = model_cfg.wired_under_level;
    end else begin
      r.backlight_level = model_cfg.wireless_back_level;
      r.underglow_level = model_cfg.wireless_under_level;
    end
    r.leds_on    = m_enabled;
    r.idle_phase = m_phase;
    return r;
  endfunction

  task report_mismatch(string what, int got_v, int want_v);
    if (errors < MAX_PRINTS)
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got_v, want_v,
               cycle_count);
    errors++;
  endtask

  always @(posedge clk) begin : check_word
    status_word_t got;
    status_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = status_word_t'(m_axis_tdata[RESULT_W-1:0]);
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected word", int'(got), 0);
      end else begin
        want = expected_status.pop_front();
        if (got.brightness_send !== want.brightness_send)
          report_mismatch("brightness_send", int'(got.brightness_send),
                          int'(want.brightness_send));
        if (got.backlight_level !== want.backlight_level)
          report_mismatch("backlight_level", int'(got.backlight_level),
                          int'(want.backlight_level));
        if (got.underglow_level !== want.underglow_level)
          report_mismatch("underglow_level", int'(got.underglow_level),
                          int'(want.underglow_level));
        if (got.sleep_send !== want.sleep_send)
          report_mismatch("sleep_send", int'(got.sleep_send), int'(want.sleep_send));
        if (got.leds_on !== want.leds_on)
          report_mismatch("leds_on", int'(got.leds_on), int'(want.leds_on));
        if (got.idle_phase !== want.idle_phase)
          report_mismatch("idle_phase", int'(got.idle_phase), int'(want.idle_phase));
      end
    end
  end

  // receiver: random stalls per word, plus a long hold-off on request
  initial begin : receiver
    int stall;
    int held;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        held         = hold_off_req;
        hold_off_req = 0;
        m_axis_tready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      stall = receiver_stalls ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready) && hold_off_req == 0) @(posedge clk);
    end
  end

  // tvalid stays high between back-to-back words
  task send_event(opcode_t op, bit mw);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, mw, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_status.push_back(next_led_status(op, mw));
  endtask

  task drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task write_reg(reg_index_t idx, logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_TRUE_SLEEP_ON:     model_cfg.true_sleep_on        = val[0];
      REG_TRUE_SLEEP_TIME:   model_cfg.sleep_time_ms        = val;
      REG_WIRED_OFF_TIME:    model_cfg.wired_off_time_ms    = val;
      REG_WLESS_OFF_TIME:    model_cfg.wireless_off_time_ms = val;
      REG_WIRED_BACK_LEVEL:  model_cfg.wired_back_level     = val[LEVEL_W-1:0];
      REG_WIRED_UNDER_LEVEL: model_cfg.wired_under_level    = val[LEVEL_W-1:0];
      REG_WLESS_BACK_LEVEL:  model_cfg.wireless_back_level  = val[LEVEL_W-1:0];
      default:               model_cfg.wireless_under_level = val[LEVEL_W-1:0];
    endcase
  endtask

  // narrow registers get random upper bits, which must be dropped
  task load_registers(bit sleep_on, logic [TIME_W-1:0] sleep_t, logic [TIME_W-1:0] wired_off,
                      logic [TIME_W-1:0] wless_off, logic [7:0] wb, logic [7:0] wu,
                      logic [7:0] lb, logic [7:0] lu);
    logic [TIME_W-1:0] junk;
    drain_results();
    junk = TIME_W'($urandom);
    write_reg(REG_TRUE_SLEEP_ON, {junk[TIME_W-1:1], sleep_on});
    write_reg(REG_TRUE_SLEEP_TIME, sleep_t);
    write_reg(REG_WIRED_OFF_TIME, wired_off);
    write_reg(REG_WLESS_OFF_TIME, wless_off);
    junk = TIME_W'($urandom);
    write_reg(REG_WIRED_BACK_LEVEL, {junk[TIME_W-1:8], wb});
    junk = TIME_W'($urandom);
    write_reg(REG_WIRED_UNDER_LEVEL, {junk[TIME_W-1:8], wu});
    junk = TIME_W'($urandom);
    write_reg(REG_WLESS_BACK_LEVEL, {junk[TIME_W-1:8], lb});
    junk = TIME_W'($urandom);
    write_reg(REG_WLESS_UNDER_LEVEL, {junk[TIME_W-1:8], lu});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task send_ticks(int n);
    repeat (n) send_event(OP_TICK, 1'($urandom_range(0, 1)));
  endtask

  task test_reset_values();
    send_ticks(2);
    send_event(OP_ENABLE, 1'b0);
    send_ticks(3);
  endtask

  task test_directed();
    load_registers(1'b1, 26'd2, 26'd0, 26'd3, 8'hFF, 8'h00, 8'h00, 8'hFF);
    send_event(OP_TICK, 1'b0);
    send_event(OP_KEY, 1'b0);        // key while on only restarts the idle count
    send_event(OP_TICK, 1'b1);
    send_event(OP_TOGGLE, 1'b0);
    send_event(OP_TICK, 1'b0);       // disabled while on: forced off
    send_event(OP_KEY, 1'b1);        // key in forced off only restarts the count
    send_event(OP_ENABLE, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_NEW_CONN, 1'b1);
    send_event(OP_CONNECTED, 1'b0);
    send_event(OP_CONNECTED, 1'b1);  // no connection pending
    send_event(OP_MODE_SET, 1'b0);   // same mode
    send_event(OP_MODE_SET, 1'b1);
    send_event(OP_TICK, 1'b0);       // wired with off time zero: never times out
    send_event(OP_DISABLE, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_TICK, 1'b1);
    send_event(OP_MODE_SET, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_TICK, 1'b0);       // sleep request in wireless
    send_event(OP_KEY, 1'b0);        // key in true sleep does not wake leds
    send_event(OP_TOGGLE, 1'b1);
    send_event(OP_TICK, 1'b0);
    send_ticks(2);
  endtask

  task test_timeouts();
    load_registers(1'b1, 26'd5, 26'd7, 26'd4, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    send_event(OP_ENABLE, 1'b0);
    send_ticks(40);
    send_event(OP_KEY, 1'b0);
    send_event(OP_ENABLE, 1'b0);
    send_event(OP_TICK, 1'b0);
    send_event(OP_MODE_SET, 1'b1);
    send_event(OP_ENABLE, 1'b1);
    send_ticks(30);
    send_event(OP_KEY, 1'b1);
    send_ticks(15);
    // zero times: never off, sleep at once once forced off
    load_registers(1'b1, 26'd0, 26'd0, 26'd0, 8'h00, 8'hFF, 8'hFF, 8'h00);
    send_event(OP_MODE_SET, 1'b0);
    send_event(OP_ENABLE, 1'b0);
    send_ticks(25);
    send_event(OP_DISABLE, 1'b0);
    send_ticks(25);
  endtask

  task run_random_events(int n);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n) begin
      if (sent % 40 == 0) begin
        sender_gaps     = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 25);
          send_ticks(len);
          sent += len;
        end
        5: begin
          send_event(OP_KEY, 1'($urandom_range(0, 1)));
          sent++;
        end
        6: begin
          send_event(opcode_t'($urandom_range(OP_ENABLE, OP_TOGGLE)),
                     1'($urandom_range(0, 1)));
          sent++;
        end
        7: begin
          send_event(OP_MODE_SET, 1'($urandom_range(0, 1)));
          sent++;
        end
        8: begin
          len = $urandom_range(0, 3);
          send_event(OP_NEW_CONN, 1'($urandom_range(0, 1)));
          send_ticks(len);
          send_event(OP_CONNECTED, 1'($urandom_range(0, 1)));
          sent += 2 + len;
        end
        default: begin
          send_event(opcode_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
          sent++;
        end
      endcase
    end
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task test_random();
    load_registers(1'b1, TIME_W'($urandom_range(0, 40)), TIME_W'($urandom_range(0, 40)),
                   TIME_W'($urandom_range(0, 40)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    run_random_events(70);
    load_registers(1'b0, TIME_W'($urandom_range(0, 40)), TIME_W'($urandom_range(0, 40)),
                   26'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random_events(50);
    load_registers(1'b1, 26'd65535000, 26'h3FFFFFF, 26'd65535000, 8'hFF, 8'hFF, 8'h00, 8'h00);
    run_random_events(50);
    load_registers(1'b1, TIME_W'($urandom_range(1, 10)), TIME_W'($urandom_range(1, 10)),
                   TIME_W'($urandom_range(1, 10)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    run_random_events(50);
  endtask

  // output held off long enough that the block backs up into its input
  task test_backpressure();
    drain_results();
    sender_gaps  = 1'b0;
    hold_off_req = 90;
    repeat (40) send_event(opcode_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    sender_gaps = 1'b1;
    drain_results();
    repeat (10) send_event(opcode_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst             <= 1'b1;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    cfg_we          <= 1'b0;
    cfg_addr        <= '0;
    cfg_wdata       <= '0;
    errors          = 0;
    cycle_count     = 0;
    hold_off_req    = 0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed();
    test_timeouts();
    test_backpressure();
    test_random();
    drain_results();

    if (errors == 0 && expected_status.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
